/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is low.
`define PGM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Overlapping implication from an antecedent to a consequent.
`define PGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/pgm_pkg.sv */
// ----------------------------------------------------------------------------
// PCM16 gain mixer package
// Widths, reset values and register codes shared by the mixer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgm_pkg;

  localparam int SampleW = 16;
  localparam int GainW = 16;
  localparam int CfgIdxW = 8;
  localparam int ScaleW = 15;

  localparam int DefNumInputs = 4;
  localparam int DefGainFracBits = 12;

  // Number of gain registers reachable through the configuration port.
  localparam int NumGainRegs = 4;

  localparam logic [GainW-1:0] GainReset = 16'd4096;
  localparam logic [ScaleW-1:0] PosScale = 15'd32767;

  typedef enum logic [1:0] {
    CfgGainA = 2'd0,
    CfgGainB = 2'd1,
    CfgGainC = 2'd2,
    CfgGainD = 2'd3
  } cfg_reg_e;

endpackage

/* src/pcm16_gain_mixer.sv */
// ----------------------------------------------------------------------------
// PCM16 gain mixer
// Weighted sum of NUM_INPUTS PCM16 streams with per-stream Q4.12 gains.
// ----------------------------------------------------------------------------
// One frame enters per cycle while s_axis_tready is high; the four register
// stages are the gain multipliers, the adder tree, the range check with the
// 32767 scaling multiplier, and the rounding output register. Master-side
// back pressure stalls only the full stages, so empty stages keep absorbing
// frames. Gain registers are written through the configuration channel
// (always ready); the user must write them only while no frame is in flight,
// which the block does not enforce. An out of range mix gives a zero sample with tuser set.
`timescale 1ns / 1ps

module pcm16_gain_mixer import pgm_pkg::*; #(
  parameter int NUM_INPUTS = DefNumInputs,
  parameter int GAIN_FRAC_BITS = DefGainFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CfgIdxW-1:0]               cfg_index_i,
  input  logic [GainW-1:0]                 cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_a, sample_b, ... each 16 bits, lowest bits first
  input  logic [NUM_INPUTS*SampleW-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mixed_sample
  output logic [SampleW-1:0]               m_axis_tdata,
  // mix_status
  output logic [0:0]                       m_axis_tuser
);

  localparam int ProdW = SampleW + GainW;
  localparam int SumW = ProdW + 1 + $clog2(NUM_INPUTS);
  localparam int NormShift = SampleW - 1 + GAIN_FRAC_BITS;
  localparam int MagW = NormShift + 1;
  localparam int ValW = MagW + ScaleW;

  localparam logic signed [SumW-1:0] FullPos = SumW'(1) << NormShift;
  localparam logic signed [SumW-1:0] FullNeg = -FullPos;
  localparam logic [ValW:0] RndNeg = (ValW + 1)'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [ValW:0] RndPos = (ValW + 1)'(1) << (NormShift - 1);

  logic [GainW-1:0] gain_q [NUM_INPUTS];

  logic adv_p, adv_s, adv_r, adv_o;

  logic                    p_valid_q;
  logic signed [ProdW-1:0] p_prod_q [NUM_INPUTS];

  logic                   s_valid_q;
  logic signed [SumW-1:0] s_sum_q;
  logic signed [SumW-1:0] sum_d;

  logic            r_valid_q;
  logic            r_oor_q;
  logic            r_neg_q;
  logic [ValW-1:0] r_val_q;
  logic            oor_d;
  logic            neg_d;
  logic [SumW-1:0] abs_d;
  logic [MagW-1:0] mag_d;
  logic [ValW-1:0] pos_num_d;

  logic               o_valid_q;
  logic [SampleW-1:0] o_data_q;
  logic               o_user_q;
  logic [ValW:0]      q_neg_d;
  logic [ValW:0]      q_pos_d;
  logic [SampleW-1:0] res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        gain_q[i] <= GainReset;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        if (i < NumGainRegs && cfg_index_i == CfgIdxW'(i)) begin
          gain_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign adv_o = !o_valid_q || m_axis_tready;
  assign adv_r = !r_valid_q || adv_o;
  assign adv_s = !s_valid_q || adv_r;
  assign adv_p = !p_valid_q || adv_s;
  assign s_axis_tready = adv_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (adv_p) p_valid_q <= s_axis_tvalid;
      if (adv_s) s_valid_q <= p_valid_q;
      if (adv_r) r_valid_q <= s_valid_q;
      if (adv_o) o_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p && s_axis_tvalid) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        p_prod_q[i] <= $signed(s_axis_tdata[i*SampleW +: SampleW])
                       * $signed({1'b0, gain_q[i]});
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      sum_d = sum_d + SumW'(p_prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s && p_valid_q) begin
      s_sum_q <= sum_d;
    end
  end

  assign oor_d = (s_sum_q > FullPos) || (s_sum_q < FullNeg);
  assign neg_d = s_sum_q[SumW-1];
  assign abs_d = neg_d ? SumW'(-s_sum_q) : SumW'(s_sum_q);
  assign mag_d = abs_d[MagW-1:0];
  assign pos_num_d = ValW'(mag_d) * ValW'(PosScale);

  always_ff @(posedge clk_i) begin
    if (adv_r && s_valid_q) begin
      r_oor_q <= oor_d;
      r_neg_q <= neg_d;
      r_val_q <= neg_d ? ValW'(mag_d) : pos_num_d;
    end
  end

  assign q_neg_d = ({1'b0, r_val_q} + RndNeg) >> GAIN_FRAC_BITS;
  assign q_pos_d = ({1'b0, r_val_q} + RndPos) >> NormShift;
  assign res_d = r_neg_q ? (-q_neg_d[SampleW-1:0]) : q_pos_d[SampleW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv_o && r_valid_q) begin
      o_data_q <= r_oor_q ? '0 : res_d;
      o_user_q <= r_oor_q;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata = o_data_q;
  assign m_axis_tuser = o_user_q;

endmodule

/* src/pgm_checker.sv */
// ----------------------------------------------------------------------------
// PCM16 gain mixer checker
// Port-level assertions on the mixer, attached to the mixer module by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pgm_checker import pgm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [SampleW-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  `PGM_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "stalled output beat dropped")
  `PGM_ASSERT(a_out_stable, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output beat changed")
  `PGM_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "out of range beat carries a nonzero sample")
  `PGM_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled while the output register is empty")
  `PGM_ASSERT_IMP(a_in_to_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && m_axis_tready, ##4 m_axis_tvalid || !$past(m_axis_tready, 1) || !$past(m_axis_tready, 2) || !$past(m_axis_tready, 3), "accepted beat did not reach the output")

endmodule

bind pcm16_gain_mixer pgm_checker u_pgm_checker (.*);
